// File: design/wsbpe_pkg.sv
// ----------------------------------------------------------------------------
// wsbpe_pkg
// Shared types and constants of the LED strip bit pulse encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wsbpe_pkg;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] FULL_BRIGHTNESS = 8'd255;
  localparam logic [4:0] LATCH_STEP      = 5'd0;
  localparam logic [4:0] FIRST_BIT_STEP  = 5'd1;
  localparam logic [4:0] LAST_STEP       = 5'd16;

  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [2:0] REG_ONE_LOW    = 3'd2;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd3;
  localparam logic [2:0] REG_ZERO_LOW   = 3'd4;
  localparam logic [2:0] REG_LATCH      = 3'd5;

  typedef struct packed {
    logic [7:0] value;
    logic       first;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  one_high;
    logic [7:0]  one_low;
    logic [7:0]  zero_high;
    logic [7:0]  zero_low;
    logic [15:0] latch;
  } timing_t;

endpackage

`default_nettype wire

// File: design/wsbpe_front.sv
// ----------------------------------------------------------------------------
// wsbpe_front
// Accepts colour bytes, applies brightness scaling and queues the item.
// ----------------------------------------------------------------------------
`default_nettype none

module wsbpe_front
  import wsbpe_pkg::*;
(
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [7:0] color_byte,
  input  wire logic       first_of_frame,
  input  wire logic       last_of_frame,
  input  wire logic [7:0] brightness,
  input  wire logic       q_full,
  output logic            q_push,
  output byte_item_t      q_entry
);

  logic [15:0] product;

  assign product    = {8'h00, color_byte} * {8'h00, brightness};
  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  always_comb begin
    q_entry.value = (brightness == FULL_BRIGHTNESS) ? color_byte : product[15:8];
    q_entry.first = first_of_frame;
    q_entry.last  = last_of_frame;
  end

endmodule

`default_nettype wire

// File: design/wsbpe_queue.sv
// ----------------------------------------------------------------------------
// wsbpe_queue
// Short item queue between the front and the segment sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module wsbpe_queue
  import wsbpe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire byte_item_t push_entry,
  input  wire logic       pop,
  output byte_item_t      head,
  output logic            full,
  output logic            empty
);

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

  byte_item_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/wsbpe_back.sv
// ----------------------------------------------------------------------------
// wsbpe_back
// Segment sequencer: turns one queued item into latch and bit segments.
// ----------------------------------------------------------------------------
`default_nettype none

module wsbpe_back
  import wsbpe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire timing_t    timing,
  input  wire byte_item_t head,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            seg_valid,
  input  wire logic       seg_stall,
  output logic            seg_level,
  output logic [15:0]     seg_ticks,
  output logic            item_done,
  output logic            frame_done
);

  byte_item_t cur;
  logic       busy;
  logic [4:0] step;

  logic       load_en;
  logic       last_step;
  logic [3:0] idx;
  logic [2:0] bit_pos;
  logic       bit_one;
  logic       lvl;
  logic [15:0] ticks;

  assign load_en   = !seg_valid || !seg_stall;
  assign last_step = (step == LAST_STEP);
  assign q_pop     = !q_empty && (!busy || (load_en && last_step));

  assign idx     = 4'(step - FIRST_BIT_STEP);
  assign bit_pos = 3'd7 - idx[3:1];
  assign bit_one = cur.value[bit_pos];

  always_comb begin
    if (step == LATCH_STEP) begin
      lvl   = 1'b0;
      ticks = timing.latch;
    end else if (!idx[0]) begin
      lvl   = 1'b1;
      ticks = {8'h00, bit_one ? timing.one_high : timing.zero_high};
    end else begin
      lvl   = 1'b0;
      ticks = {8'h00, bit_one ? timing.one_low : timing.zero_low};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      seg_valid <= 1'b0;
      step      <= LATCH_STEP;
    end else begin
      if (load_en) begin
        seg_valid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
        step <= head.first ? LATCH_STEP : FIRST_BIT_STEP;
      end else if (load_en && busy) begin
        if (last_step) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
    end
    if (load_en && busy) begin
      seg_level  <= lvl;
      seg_ticks  <= ticks;
      item_done  <= last_step;
      frame_done <= last_step && cur.last;
    end
  end

endmodule

`default_nettype wire

// File: design/ws2812_bit_pulse_encoder_unit.sv
// ----------------------------------------------------------------------------
// ws2812_bit_pulse_encoder_unit
// LED strip bit pulse encoder: colour bytes in, timed line segments out.
// ----------------------------------------------------------------------------
// An item's first segment passes the queue, the busy and step registers and
// the segment outputs. Throughput: one segment a cycle while seg_stall is low,
// 17 segments for a frame's first item, 16 otherwise, no gap while queued.
// Reset clears the queue, the sequencer and the output valid, and loads the
// timing registers with their defaults; no clearing pass is needed.
`default_nettype none

module ws2812_bit_pulse_encoder_unit
  import wsbpe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [7:0]  color_byte,
  input  wire logic        first_of_frame,
  input  wire logic        last_of_frame,
  output logic             seg_valid,
  input  wire logic        seg_stall,
  output logic             seg_level,
  output logic [15:0]      seg_ticks,
  output logic             item_done,
  output logic             frame_done,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [7:0] brightness;
  timing_t    timing;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  byte_item_t q_entry;
  byte_item_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness       <= FULL_BRIGHTNESS;
      timing.one_high  <= 8'd5;
      timing.one_low   <= 8'd2;
      timing.zero_high <= 8'd1;
      timing.zero_low  <= 8'd6;
      timing.latch     <= 16'd6400;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BRIGHTNESS: brightness       <= cfg_data[7:0];
        REG_ONE_HIGH:   timing.one_high  <= cfg_data[7:0];
        REG_ONE_LOW:    timing.one_low   <= cfg_data[7:0];
        REG_ZERO_HIGH:  timing.zero_high <= cfg_data[7:0];
        REG_ZERO_LOW:   timing.zero_low  <= cfg_data[7:0];
        REG_LATCH:      timing.latch     <= cfg_data;
        default: ;
      endcase
    end
  end

  wsbpe_front u_front (
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .color_byte     (color_byte),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame),
    .brightness     (brightness),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  wsbpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  wsbpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .timing     (timing),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .seg_valid  (seg_valid),
    .seg_stall  (seg_stall),
    .seg_level  (seg_level),
    .seg_ticks  (seg_ticks),
    .item_done  (item_done),
    .frame_done (frame_done)
  );

endmodule

`default_nettype wire
